[sv/window_filter_3x3_multimode_macros.svh]
// Assertion macros used by the window filter top level
`ifndef WINDOW_FILTER_3X3_MULTIMODE_MACROS_SVH
`define WINDOW_FILTER_3X3_MULTIMODE_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define WF3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked in the next cycle
`define WF3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/wf3_pkg.sv]
// Package: shared types, constants and helper functions of the window filter
package wf3_pkg;

  localparam int PIX_W     = 8;
  localparam int ROW_W     = 12;
  localparam int COL_W     = 10;
  localparam int WID_W     = 11;
  localparam int CFG_W     = 12;
  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int CSUM_W    = 10;
  localparam int SUM_W     = 12;

  localparam logic [WID_W-1:0] MIN_SIZE_W = 11'd3;
  localparam logic [WID_W-1:0] MAX_SIZE_W = WID_W'(MAX_WIDTH);
  localparam logic [ROW_W-1:0] MIN_SIZE_H = 12'd3;

  // reciprocal of nine, 16 fractional bits; exact floor for sums up to 9*255
  localparam logic [12:0] RECIP9 = 13'd7282;
  localparam int          RECIP_SH = 16;

  localparam logic [PIX_W-1:0] PIX_FULL = 8'd255;

  typedef enum logic [2:0] {
    MODE_RANGE  = 3'd0,
    MODE_MAX    = 3'd1,
    MODE_MIN    = 3'd2,
    MODE_MEAN   = 3'd3,
    MODE_MEDIAN = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_THRESH = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } reg_idx_t;

  localparam logic [2:0]       RST_MODE   = MODE_MEAN;
  localparam logic [PIX_W-1:0] RST_THRESH = 8'd50;
  localparam logic [WID_W-1:0] RST_WIDTH  = 11'd640;
  localparam logic [ROW_W-1:0] RST_HEIGHT = 12'd480;

  // one window column, top to bottom
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } column_t;

  // position tag that travels with a result
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             done;
    logic             zero;
  } meta_t;

  function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // sorted column: top = smallest, mid = median, bot = largest
  function automatic column_t sort3(input column_t x);
    column_t s;
    s.top = min2(min2(x.top, x.mid), x.bot);
    s.mid = med3(x.top, x.mid, x.bot);
    s.bot = max2(max2(x.top, x.mid), x.bot);
    return s;
  endfunction

endpackage

[sv/wf3_ifs.sv]
// Stream interfaces: pixel input channel and filtered result channel
interface wf3_pix_if;
  logic                    valid;
  logic                    ready;
  logic [wf3_pkg::PIX_W-1:0] pixel;
  logic                    frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface wf3_res_if;
  logic                      valid;
  logic                      ready;
  logic [wf3_pkg::PIX_W-1:0] out_value;
  logic [wf3_pkg::ROW_W-1:0] out_row;
  logic [wf3_pkg::COL_W-1:0] out_col;
  logic                      frame_done;

  modport source (output valid, output out_value, output out_row, output out_col,
                  output frame_done, input ready);
  modport sink   (input valid, input out_value, input out_row, input out_col,
                  input frame_done, output ready);
endinterface

[sv/wf3_ram.sv]
// Generic simple dual-port RAM, read-first, registered read
module wf3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/wf3_cell.sv]
// Window column cell: holds one 3-pixel column and hands it to its neighbor
module wf3_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  wf3_pkg::column_t col_in,
  output wf3_pkg::column_t col
);

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (shift) begin
      col <= col_in;
    end
  end

endmodule

[sv/wf3_reduce.sv]
// Two-stage window reducer: column sort, then max/min/sum/median and mode select
module wf3_reduce (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  wf3_pkg::meta_t              in_meta,
  input  wf3_pkg::column_t            col0,
  input  wf3_pkg::column_t            col1,
  input  wf3_pkg::column_t            col2,
  input  logic [2:0]                  filter_mode,
  input  logic [wf3_pkg::PIX_W-1:0]   edge_threshold,
  output logic                        res_valid,
  output wf3_pkg::meta_t              res_meta,
  output logic [wf3_pkg::PIX_W-1:0]   res_value
);

  // stage A: sorted columns and column sums
  logic                        a_valid;
  wf3_pkg::meta_t              a_meta;
  wf3_pkg::column_t            a_s0, a_s1, a_s2;
  logic [wf3_pkg::CSUM_W-1:0]  a_c0, a_c1, a_c2;

  // stage B: window aggregates
  logic                        b_valid;
  wf3_pkg::meta_t              b_meta;
  logic [wf3_pkg::PIX_W-1:0]   b_maxlo, b_medmd, b_minhi, b_mx, b_mn;
  logic [wf3_pkg::SUM_W-1:0]   b_sum;

  logic [24:0]                 mean_prod;
  logic [wf3_pkg::PIX_W-1:0]   mean_val;
  logic [wf3_pkg::PIX_W-1:0]   med_val;
  logic [wf3_pkg::PIX_W-1:0]   range_val;
  logic [wf3_pkg::PIX_W-1:0]   mode_val;

  function automatic logic [wf3_pkg::CSUM_W-1:0] csum(input wf3_pkg::column_t x);
    return wf3_pkg::CSUM_W'(x.top) + wf3_pkg::CSUM_W'(x.mid) + wf3_pkg::CSUM_W'(x.bot);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
    end
  end

  // column sort and sums
  always_ff @(posedge clk) begin
    if (en) begin
      a_meta <= in_meta;
      a_s0   <= wf3_pkg::sort3(col0);
      a_s1   <= wf3_pkg::sort3(col1);
      a_s2   <= wf3_pkg::sort3(col2);
      a_c0   <= csum(col0);
      a_c1   <= csum(col1);
      a_c2   <= csum(col2);
    end
  end

  // cross-column aggregates
  always_ff @(posedge clk) begin
    if (en) begin
      b_meta  <= a_meta;
      b_maxlo <= wf3_pkg::max2(wf3_pkg::max2(a_s0.top, a_s1.top), a_s2.top);
      b_medmd <= wf3_pkg::med3(a_s0.mid, a_s1.mid, a_s2.mid);
      b_minhi <= wf3_pkg::min2(wf3_pkg::min2(a_s0.bot, a_s1.bot), a_s2.bot);
      b_mx    <= wf3_pkg::max2(wf3_pkg::max2(a_s0.bot, a_s1.bot), a_s2.bot);
      b_mn    <= wf3_pkg::min2(wf3_pkg::min2(a_s0.top, a_s1.top), a_s2.top);
      b_sum   <= wf3_pkg::SUM_W'(a_c0) + wf3_pkg::SUM_W'(a_c1) + wf3_pkg::SUM_W'(a_c2);
    end
  end

  // mean by reciprocal multiply, median of nine from the sorted columns
  assign mean_prod = 25'(b_sum) * 25'(wf3_pkg::RECIP9);
  assign mean_val  = mean_prod[wf3_pkg::RECIP_SH +: wf3_pkg::PIX_W];
  assign med_val   = wf3_pkg::med3(b_maxlo, b_medmd, b_minhi);
  assign range_val = ((b_mx - b_mn) > edge_threshold) ? wf3_pkg::PIX_FULL : '0;

  // mode select
  always_comb begin
    unique case (wf3_pkg::mode_t'(filter_mode))
      wf3_pkg::MODE_RANGE:  mode_val = range_val;
      wf3_pkg::MODE_MAX:    mode_val = b_mx;
      wf3_pkg::MODE_MIN:    mode_val = b_mn;
      wf3_pkg::MODE_MEAN:   mode_val = mean_val;
      wf3_pkg::MODE_MEDIAN: mode_val = med_val;
      default:              mode_val = '0;
    endcase
  end

  assign res_valid = b_valid;
  assign res_meta  = b_meta;
  assign res_value = b_meta.zero ? '0 : mode_val;

endmodule

[sv/window_filter_3x3_multimode.sv]
// Top level: 3x3 window filter with line stores, column-cell window and reducer
//
//  channel   dir  handshake     payload
//  pix_in    in   valid/ready   pixel, frame_start
//  res_out   out  valid/ready   out_value, out_row, out_col, frame_done
//  cfg       in   cfg_we        cfg_index, cfg_data
//
// One pixel per clock sustained while res_out does not stall; a result passes
// line store read, window shift, two reducer stages and output register.
// rst is synchronous; it clears position, window and pipeline valids and
// loads register defaults. Line stores are not cleared.
// The whole pipeline advances when the output register is empty or taken,
// so a stall on res_out holds pix_in.ready low in the same cycle.
`include "window_filter_3x3_multimode_macros.svh"

module window_filter_3x3_multimode (
  input  logic                      clk,
  input  logic                      rst,
  wf3_pix_if.sink                   pix_in,
  wf3_res_if.source                 res_out,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [wf3_pkg::CFG_W-1:0] cfg_data
);

  // configuration
  logic [2:0]                filter_mode;
  logic [wf3_pkg::PIX_W-1:0] edge_threshold;
  logic [wf3_pkg::WID_W-1:0] image_width;
  logic [wf3_pkg::ROW_W-1:0] image_height;
  logic [wf3_pkg::WID_W-1:0] w_eff;
  logic [wf3_pkg::ROW_W-1:0] h_eff;

  // position
  logic [wf3_pkg::COL_W-1:0] column_count, column_count_next;
  logic [wf3_pkg::ROW_W-1:0] row_count, row_count_next;
  logic [wf3_pkg::COL_W-1:0] c0;
  logic [wf3_pkg::ROW_W-1:0] r0;
  logic                      emit;
  wf3_pkg::meta_t            meta0;
  logic                      wrap;

  logic                      en;
  logic                      accept;

  // stage 1: line store read
  logic                       s1_valid;
  logic                       s1_emit;
  wf3_pkg::meta_t             s1_meta;
  logic [wf3_pkg::PIX_W-1:0]  s1_px;
  logic [wf3_pkg::ADDR_W-1:0] s1_idx;
  logic                       s1_fwd;
  logic [wf3_pkg::PIX_W-1:0]  s1_fwd_data;
  logic [wf3_pkg::PIX_W-1:0]  up_rdata, lo_rdata, up_val;

  // stage 2: window
  logic                       s2_valid;
  wf3_pkg::meta_t             s2_meta;
  wf3_pkg::column_t           new_col, col0, col1, col2;

  logic                       red_valid;
  wf3_pkg::meta_t             red_meta;
  logic [wf3_pkg::PIX_W-1:0]  red_value;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode    <= wf3_pkg::RST_MODE;
      edge_threshold <= wf3_pkg::RST_THRESH;
      image_width    <= wf3_pkg::RST_WIDTH;
      image_height   <= wf3_pkg::RST_HEIGHT;
    end else if (cfg_we) begin
      unique case (wf3_pkg::reg_idx_t'(cfg_index))
        wf3_pkg::REG_MODE:   filter_mode    <= cfg_data[2:0];
        wf3_pkg::REG_THRESH: edge_threshold <= cfg_data[wf3_pkg::PIX_W-1:0];
        wf3_pkg::REG_WIDTH:  image_width    <= cfg_data[wf3_pkg::WID_W-1:0];
        wf3_pkg::REG_HEIGHT: image_height   <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp frame size
  always_comb begin
    if (image_width < wf3_pkg::MIN_SIZE_W) begin
      w_eff = wf3_pkg::MIN_SIZE_W;
    end else if (image_width > wf3_pkg::MAX_SIZE_W) begin
      w_eff = wf3_pkg::MAX_SIZE_W;
    end else begin
      w_eff = image_width;
    end
    h_eff = (image_height < wf3_pkg::MIN_SIZE_H) ? wf3_pkg::MIN_SIZE_H : image_height;
  end

  assign en             = !res_out.valid || res_out.ready;
  assign pix_in.ready   = en;
  assign accept         = pix_in.valid && en;

  // position of the incoming pixel and its result tag
  always_comb begin
    c0   = pix_in.frame_start ? '0 : column_count;
    r0   = pix_in.frame_start ? '0 : row_count;
    emit = (r0 != '0) && (c0 != '0) && (r0 < h_eff) &&
           (wf3_pkg::WID_W'(c0) < w_eff);
    meta0.row  = r0 - 1'b1;
    meta0.col  = c0 - 1'b1;
    meta0.done = (r0 == h_eff - 1'b1) && (wf3_pkg::WID_W'(c0) == w_eff - 1'b1);
    meta0.zero = (r0 == 12'd1) || (c0 == 10'd1);
    wrap = (wf3_pkg::WID_W'(c0) + 1'b1) >= w_eff;
    if (wrap) begin
      column_count_next = '0;
      row_count_next    = ((13'(r0) + 1'b1) >= 13'(h_eff)) ? '0 : r0 + 1'b1;
    end else begin
      column_count_next = c0 + 1'b1;
      row_count_next    = r0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // line stores: lower takes the new pixel, upper takes what lower held
  wf3_ram #(.WIDTH(wf3_pkg::PIX_W), .DEPTH(wf3_pkg::MAX_WIDTH)) u_lower (
    .clk   (clk),
    .we    (accept),
    .waddr (c0[wf3_pkg::ADDR_W-1:0]),
    .wdata (pix_in.pixel),
    .re    (en),
    .raddr (c0[wf3_pkg::ADDR_W-1:0]),
    .rdata (lo_rdata)
  );

  wf3_ram #(.WIDTH(wf3_pkg::PIX_W), .DEPTH(wf3_pkg::MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (en && s1_valid),
    .waddr (s1_idx),
    .wdata (lo_rdata),
    .re    (en),
    .raddr (c0[wf3_pkg::ADDR_W-1:0]),
    .rdata (up_rdata)
  );

  // stage 1 registers; forward the upper write still in flight at same address
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_emit     <= emit;
      s1_meta     <= meta0;
      s1_px       <= pix_in.pixel;
      s1_idx      <= c0[wf3_pkg::ADDR_W-1:0];
      s1_fwd      <= s1_valid && (s1_idx == c0[wf3_pkg::ADDR_W-1:0]);
      s1_fwd_data <= lo_rdata;
    end
  end

  assign up_val      = s1_fwd ? s1_fwd_data : up_rdata;
  assign new_col.top = up_val;
  assign new_col.mid = lo_rdata;
  assign new_col.bot = s1_px;

  // window: chain of column cells, newest on the right
  wf3_cell u_cell2 (.clk(clk), .rst(rst), .shift(en && s1_valid), .col_in(new_col), .col(col2));
  wf3_cell u_cell1 (.clk(clk), .rst(rst), .shift(en && s1_valid), .col_in(col2), .col(col1));
  wf3_cell u_cell0 (.clk(clk), .rst(rst), .shift(en && s1_valid), .col_in(col1), .col(col0));

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_meta <= s1_meta;
    end
  end

  wf3_reduce u_reduce (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (s2_valid),
    .in_meta        (s2_meta),
    .col0           (col0),
    .col1           (col1),
    .col2           (col2),
    .filter_mode    (filter_mode),
    .edge_threshold (edge_threshold),
    .res_valid      (red_valid),
    .res_meta       (red_meta),
    .res_value      (red_value)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_out.valid <= 1'b0;
    end else if (en) begin
      res_out.valid <= red_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_out.out_value  <= red_value;
      res_out.out_row    <= red_meta.row;
      res_out.out_col    <= red_meta.col;
      res_out.frame_done <= red_meta.done;
    end
  end

  // checks
  `WF3_ASSERT(a_border_zero, !(res_out.valid && (res_out.out_row == '0 || res_out.out_col == '0)) || res_out.out_value == '0, "border result not zero")
  `WF3_ASSERT(a_done_row, !(res_out.valid && res_out.frame_done) || res_out.out_row == h_eff - 12'd2, "frame_done on wrong row")
  `WF3_ASSERT(a_range_levels, !(res_out.valid && filter_mode == wf3_pkg::MODE_RANGE) || res_out.out_value == '0 || res_out.out_value == wf3_pkg::PIX_FULL, "range edge value not binary")
  `WF3_ASSERT_NEXT(a_fwd_addr, en && accept && s1_valid && s1_idx == c0[wf3_pkg::ADDR_W-1:0], s1_fwd, "upper store forward missed")

endmodule
